### rtl/pfbsd_pkg.sv
// Shared types and constants for the font segment deframer.
// No dependencies; used by pfbsd_parse, the top level and the checker.
package pfbsd_pkg;

    localparam int unsigned WINDOW_BYTES = 11;
    localparam int unsigned WINDOW_W     = 8 * WINDOW_BYTES;
    localparam int unsigned OUT_TDATA_W  = 112;

    localparam logic [7:0]  SEG_MARK     = 8'h80;
    localparam logic [7:0]  SEG_ASCII    = 8'd1;
    localparam logic [7:0]  SEG_BINARY   = 8'd2;
    localparam logic [7:0]  SEG_EOF      = 8'd3;
    localparam logic [31:0] TRAILER_LEN  = 32'd520;

    localparam logic [39:0] EEXEC_STR    = "eexec";
    localparam logic [87:0] CTM_STR      = "cleartomark";

    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_TRUNCATED = 3'd1;
    localparam logic [2:0] STAT_BAD_TYPE  = 3'd2;
    localparam logic [2:0] STAT_NO_HEADER = 3'd3;
    localparam logic [2:0] STAT_CLAMPED   = 3'd4;

    // Parsed word handed from the parse stage to the length stage.
    typedef struct packed {
        logic [7:0]  data;
        logic        byte_vld;
        logic        sum_vld;
        logic        segmented;
        logic [2:0]  status;
        logic [31:0] len1;       // segmented lengths
        logic [31:0] len2;
        logic [31:0] len3;
        logic [31:0] size;       // plain file: byte count
        logic [32:0] eexec_len;  // plain file: eexec offset + 6
        logic        eexec_ok;   // eexec seen at a nonzero offset
        logic        ctm_ok;     // cleartomark seen at a nonzero offset
    } t_stage_a;

endpackage

### rtl/pfbsd_parse.sv
// Byte parser: header/segment state, length capture and keyword window.
// Depends on pfbsd_pkg. Produces one registered t_stage_a word per result.
module pfbsd_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_drain,
    output logic              o_valid,
    output pfbsd_pkg::t_stage_a o_stage
);
    import pfbsd_pkg::*;

    typedef enum logic [2:0] {
        PH_START, PH_HDR_TYPE, PH_HDR_LEN, PH_PAYLOAD, PH_HDR_MARK, PH_PLAIN, PH_DRAIN
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [1:0]    r_hidx, n_hidx;
    logic          r_kind_bin, n_kind_bin;
    logic [31:0]   r_remain, n_remain;
    logic [31:0]   r_accum, n_accum;
    logic [31:0]   r_len1, n_len1;
    logic [31:0]   r_len2, n_len2;
    logic [31:0]   r_len3, n_len3;
    logic [31:0]   r_count, n_count;
    logic [WINDOW_W-1:0] r_win, n_win;
    logic [32:0]   r_eexec_len, n_eexec_len;
    logic          r_eexec_found, n_eexec_found;
    logic          r_eexec_nz, n_eexec_nz;
    logic          r_ctm_found, n_ctm_found;
    logic          r_ctm_start, n_ctm_start;

    logic          r_valid;
    t_stage_a      r_stage, n_stage;
    logic          push;

    always_comb begin
        logic ended;
        logic plain;
        logic [WINDOW_W-1:0] win_sh;
        logic [31:0] acc_full;

        n_phase       = r_phase;
        n_hidx        = r_hidx;
        n_kind_bin    = r_kind_bin;
        n_remain      = r_remain;
        n_accum       = r_accum;
        n_len1        = r_len1;
        n_len2        = r_len2;
        n_len3        = r_len3;
        n_count       = r_count;
        n_win         = r_win;
        n_eexec_len   = r_eexec_len;
        n_eexec_found = r_eexec_found;
        n_eexec_nz    = r_eexec_nz;
        n_ctm_found   = r_ctm_found;
        n_ctm_start   = r_ctm_start;
        n_stage       = '0;
        ended         = 1'b0;
        plain         = 1'b0;
        win_sh        = {r_win[WINDOW_W-9:0], i_byte};
        acc_full      = '0;

        unique case (r_phase)
            PH_START: begin
                if (i_byte == SEG_MARK) begin
                    n_phase = PH_HDR_TYPE;
                end else begin
                    n_phase = PH_PLAIN;
                    plain   = 1'b1;
                end
            end
            PH_PLAIN: begin
                plain = 1'b1;
            end
            PH_HDR_MARK: begin
                if (i_byte == SEG_MARK) begin
                    n_phase = PH_HDR_TYPE;
                end else begin
                    n_stage.sum_vld = 1'b1;
                    n_stage.status  = STAT_NO_HEADER;
                    n_phase         = PH_DRAIN;
                    ended           = 1'b1;
                end
            end
            PH_HDR_TYPE: begin
                if (i_byte == SEG_ASCII || i_byte == SEG_BINARY) begin
                    n_kind_bin = (i_byte == SEG_BINARY);
                    n_hidx     = '0;
                    n_accum    = '0;
                    n_phase    = PH_HDR_LEN;
                end else begin
                    n_stage.sum_vld = 1'b1;
                    n_stage.status  = (i_byte == SEG_EOF) ? STAT_OK : STAT_BAD_TYPE;
                    n_phase         = PH_DRAIN;
                    ended           = 1'b1;
                end
            end
            PH_HDR_LEN: begin
                // little-endian length, one byte per beat
                unique case (r_hidx)
                    2'd0: acc_full = {r_accum[31:8], i_byte};
                    2'd1: acc_full = {r_accum[31:16], i_byte, r_accum[7:0]};
                    2'd2: acc_full = {r_accum[31:24], i_byte, r_accum[15:0]};
                    default: acc_full = {i_byte, r_accum[23:0]};
                endcase
                n_accum = acc_full;
                n_hidx  = r_hidx + 2'd1;
                if (r_hidx == 2'd3) begin
                    if (r_kind_bin) begin
                        n_len2 = acc_full;
                    end else if (r_len1 == '0) begin
                        n_len1 = acc_full;
                    end else begin
                        n_len3 = acc_full;
                    end
                    n_remain = acc_full;
                    n_phase  = (acc_full != '0) ? PH_PAYLOAD : PH_HDR_MARK;
                end
            end
            PH_PAYLOAD: begin
                n_stage.data     = i_byte;
                n_stage.byte_vld = 1'b1;
                n_remain         = r_remain - 32'd1;
                if (r_remain == 32'd1) begin
                    n_phase = PH_HDR_MARK;
                end
            end
            default: begin
                ended = 1'b1;
            end
        endcase

        if (plain) begin
            ended            = 1'b1;
            n_win            = win_sh;
            n_count          = r_count + 32'd1;
            n_stage.data     = i_byte;
            n_stage.byte_vld = 1'b1;
            if (!i_last) begin
                if (!r_eexec_found && win_sh[39:0] == EEXEC_STR) begin
                    n_eexec_found = 1'b1;
                    n_eexec_nz    = (r_count != 32'd4);
                    n_eexec_len   = {1'b0, r_count - 32'd4} + 33'd6;
                end
                if (!r_ctm_found && !r_ctm_start && win_sh == CTM_STR) begin
                    if (r_count == 32'd10) begin
                        n_ctm_start = 1'b1;
                    end else begin
                        n_ctm_found = 1'b1;
                    end
                end
            end else begin
                n_stage.sum_vld  = 1'b1;
                n_stage.size     = r_count + 32'd1;
                n_stage.eexec_len = r_eexec_len;
                n_stage.eexec_ok = r_eexec_found && r_eexec_nz;
                n_stage.ctm_ok   = r_ctm_found;
            end
        end else begin
            if (i_last && !ended) begin
                n_stage.sum_vld = 1'b1;
                n_stage.status  = STAT_TRUNCATED;
            end
            if (n_stage.sum_vld) begin
                n_stage.segmented = 1'b1;
                n_stage.len1      = n_len1;
                n_stage.len2      = n_len2;
                n_stage.len3      = n_len3;
            end
        end

        // end of file: back to the start for the next one
        if (i_last) begin
            n_phase       = PH_START;
            n_hidx        = '0;
            n_kind_bin    = 1'b0;
            n_remain      = '0;
            n_accum       = '0;
            n_len1        = '0;
            n_len2        = '0;
            n_len3        = '0;
            n_count       = '0;
            n_win         = '0;
            n_eexec_len   = '0;
            n_eexec_found = 1'b0;
            n_eexec_nz    = 1'b0;
            n_ctm_found   = 1'b0;
            n_ctm_start   = 1'b0;
        end
    end

    assign push = i_accept && (n_stage.byte_vld || n_stage.sum_vld);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_hidx        <= '0;
            r_kind_bin    <= 1'b0;
            r_remain      <= '0;
            r_accum       <= '0;
            r_len1        <= '0;
            r_len2        <= '0;
            r_len3        <= '0;
            r_count       <= '0;
            r_win         <= '0;
            r_eexec_len   <= '0;
            r_eexec_found <= 1'b0;
            r_eexec_nz    <= 1'b0;
            r_ctm_found   <= 1'b0;
            r_ctm_start   <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            if (i_accept) begin
                r_phase       <= n_phase;
                r_hidx        <= n_hidx;
                r_kind_bin    <= n_kind_bin;
                r_remain      <= n_remain;
                r_accum       <= n_accum;
                r_len1        <= n_len1;
                r_len2        <= n_len2;
                r_len3        <= n_len3;
                r_count       <= n_count;
                r_win         <= n_win;
                r_eexec_len   <= n_eexec_len;
                r_eexec_found <= n_eexec_found;
                r_eexec_nz    <= n_eexec_nz;
                r_ctm_found   <= n_ctm_found;
                r_ctm_start   <= n_ctm_start;
            end
            if (push) begin
                r_valid <= 1'b1;
            end else if (i_drain) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_valid;
    assign o_stage = r_stage;

endmodule

### rtl/pfb_font_segment_deframer.sv
// Channel   | dir | beat contents
// s (in)    | in  | tdata[7:0] in_byte; tlast last_byte
// m (out)   | out | tdata: out_byte, 3 lengths, was_segmented, status; tuser byte_valid;
//           |     | tlast summary_valid
// One byte per cycle sustained while the output is not stalled. Two register
// stages: the parse register inside pfbsd_parse, then the output register here
// where plain-file lengths are finished. A stalled output holds; the input keeps
// flowing until both stages are full. Bytes that give no result (headers,
// drained tail) occupy no stage.
// Reset is synchronous, active low, and returns the parser to start of file.
module pfb_font_segment_deframer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [7:0]                          i_s_tdata,  // [7:0] in_byte
    input  logic                                i_s_tlast,  // last_byte
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] out_byte, [39:8] length_clear, [71:40] length_encrypted,
    // [103:72] length_trailer, [104] was_segmented, [107:105] status, rest zero
    output logic [pfbsd_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    output logic                                o_m_tuser,  // byte_valid
    output logic                                o_m_tlast   // summary_valid
);
    import pfbsd_pkg::*;

    logic      a_valid;
    t_stage_a  a_stage;
    logic      a_drain;
    logic      accept;

    logic      r_o_valid;
    logic [OUT_TDATA_W-1:0] r_o_data, n_o_data;
    logic      r_o_user;
    logic      r_o_last;

    assign a_drain    = a_valid && (!r_o_valid || i_m_tready);
    assign o_s_tready = !a_valid || a_drain;
    assign accept     = i_s_tvalid && o_s_tready;

    pfbsd_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_drain  (a_drain),
        .o_valid  (a_valid),
        .o_stage  (a_stage)
    );

    // plain-file lengths: length2 = size - length1 - 520, clamped at zero
    always_comb begin
        logic [34:0] d2;
        logic [33:0] d3;
        logic [31:0] l1, l2, l3;
        logic [2:0]  st;

        d2 = {3'b0, a_stage.size} - {2'b0, a_stage.eexec_len} - {3'b0, TRAILER_LEN};
        d3 = {2'b0, a_stage.size} - {1'b0, a_stage.eexec_len};
        l1 = a_stage.len1;
        l2 = a_stage.len2;
        l3 = a_stage.len3;
        st = a_stage.status;
        if (a_stage.sum_vld && !a_stage.segmented) begin
            st = STAT_OK;
            if (a_stage.eexec_ok && a_stage.ctm_ok) begin
                l1 = a_stage.eexec_len[31:0];
                if (d2[34]) begin
                    l2 = '0;
                    l3 = d3[33] ? 32'd0 : d3[31:0];
                    st = STAT_CLAMPED;
                end else begin
                    l2 = d2[31:0];
                    l3 = TRAILER_LEN;
                end
            end else begin
                l1 = '0;
                l2 = '0;
                l3 = a_stage.size;
            end
        end
        n_o_data = {4'b0, st, a_stage.segmented, l3, l2, l1, a_stage.data};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (a_drain) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_drain) begin
            r_o_data <= n_o_data;
            r_o_user <= a_stage.byte_vld;
            r_o_last <= a_stage.sum_vld;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;
    assign o_m_tlast  = r_o_last;

endmodule

### rtl/pfbsd_check.sv
// Port-level checks for pfb_font_segment_deframer, bound to the top level.
// Depends on pfbsd_pkg.
module pfbsd_check (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [7:0]                        i_s_tdata,
    input logic                              i_s_tlast,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [pfbsd_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic                              o_m_tuser,
    input logic                              o_m_tlast
);
    import pfbsd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    a_no_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser || o_m_tlast))
        else $error("word with neither data nor summary");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[7:0] == 8'h00)
        else $error("data byte set without byte_valid");

    a_sum_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[OUT_TDATA_W-1:8] == '0)
        else $error("summary fields set without summary_valid");

    a_plain_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast && !o_m_tdata[104]
            |-> (o_m_tdata[107:105] == STAT_OK || o_m_tdata[107:105] == STAT_CLAMPED))
        else $error("plain file summary with segment status");

endmodule

bind pfb_font_segment_deframer pfbsd_check u_pfbsd_check (.*);
